// ===== design/lbm_pkg.sv =====
`default_nettype none
package lbm_pkg;

    localparam logic [3:0] MODE_NORMAL   = 4'd0;
    localparam logic [3:0] MODE_MULTIPLY = 4'd1;
    localparam logic [3:0] MODE_SCREEN   = 4'd2;
    localparam logic [3:0] MODE_OVERLAY  = 4'd3;
    localparam logic [3:0] MODE_SOFT     = 4'd4;
    localparam logic [3:0] MODE_HARD     = 4'd5;
    localparam logic [3:0] MODE_DODGE    = 4'd6;
    localparam logic [3:0] MODE_BURN     = 4'd7;
    localparam logic [3:0] MODE_DARKEN   = 4'd8;
    localparam logic [3:0] MODE_LIGHTEN  = 4'd9;
    localparam logic [3:0] MODE_DIFF     = 4'd10;
    localparam logic [3:0] MODE_EXCL     = 4'd11;

    localparam logic [0:0] REG_MODE    = 1'b0;
    localparam logic [0:0] REG_OPACITY = 1'b1;

    localparam int REM_W = 26;
    localparam int DIV_W = 16;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] div;
        logic [7:0]       quo;
        logic             sat;
        logic [7:0]       base;
    } div_beat_t;

    // round(256 * sqrt(b / 255)), ties up
    function automatic logic [8:0] sqrt_q8(input int unsigned b);
        longint unsigned t;
        longint unsigned s;
        t = 64'd65536 * 64'(b);
        s = 0;
        for (int k = 1; k <= 256; k++)
        begin
            if (64'd255 * 64'(k) * 64'(k) <= t)
            begin
                s = 64'(k);
            end
        end
        if (64'd255 * (2 * s + 1) * (2 * s + 1) <= 4 * t)
        begin
            s = s + 1;
        end
        return s[8:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/layer_blend_mode_mixer.sv =====
// channel  direction  handshake                       payload
// in       input      in_valid / in_ready             base_value, blend_value
// out      output     out_valid / out_ready           mixed_value
// cfg      input      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// one beat per cycle while the output is not stalled; two front stages, eight divide cells, mix
// the divide cells form a chain, each resolving one quotient bit per cycle
// the whole chain advances together; a stalled output holds every stage
// reset clears all stage valids and sets mode normal, opacity one
`default_nettype none
module layer_blend_mode_mixer #(
    parameter int OPACITY_FRAC_BITS = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  base_value,
    input  wire  [7:0]  blend_value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [7:0]  mixed_value,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lbm_pkg::*;

    logic        en;
    logic [3:0]  mode_reg;
    logic [8:0]  opacity_reg;
    logic        wr;
    logic [0:0]  idx;

    logic        valid_chain [9];
    div_beat_t   beat_chain  [9];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign pready   = 1'b1;
    assign idx      = paddr[2];
    assign wr       = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            opacity_reg <= 9'd256;
        end
        else if (wr)
        begin
            case (idx)
                REG_MODE:    mode_reg    <= pwdata[3:0];
                REG_OPACITY: opacity_reg <= pwdata[8:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:    prdata = 32'(mode_reg);
            REG_OPACITY: prdata = 32'(opacity_reg);
            default:     prdata = 32'd0;
        endcase
    end

    lbm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .base_value  (base_value),
        .blend_value (blend_value),
        .mode        (mode_reg),
        .out_valid   (valid_chain[0]),
        .out_beat    (beat_chain[0])
    );

    for (genvar i = 0; i < 8; i++)
    begin : g_cell
        lbm_div_cell #(
            .K (7 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_beat   (beat_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_beat  (beat_chain[i+1])
        );
    end

    lbm_mix #(
        .OPACITY_FRAC_BITS (OPACITY_FRAC_BITS)
    ) u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (valid_chain[8]),
        .in_beat     (beat_chain[8]),
        .opacity     (opacity_reg),
        .out_valid   (out_valid),
        .mixed_value (mixed_value)
    );

endmodule
`default_nettype wire

// ===== design/lbm_front.sv =====
`default_nettype none
module lbm_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  wire                    in_valid,
    input  wire  [7:0]             base_value,
    input  wire  [7:0]             blend_value,
    input  wire  [3:0]             mode,
    output logic                   out_valid,
    output lbm_pkg::div_beat_t     out_beat
);
    import lbm_pkg::*;

    logic [8:0]  sqrt_tab [256];
    logic        a_valid_reg;
    logic [15:0] p1_reg, p2_reg, bb_reg;
    logic [8:0]  sq_reg;
    logic [7:0]  b_reg, l_reg;
    logic        b_valid_reg;
    div_beat_t   beat_reg, beat_next;

    logic signed [27:0] bs, ls, p1s, p2s, bbs, sqs, n;
    logic [DIV_W-1:0]   d;

    for (genvar i = 0; i < 256; i++)
    begin : g_tab
        assign sqrt_tab[i] = sqrt_q8(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= 16'(base_value) * 16'(blend_value);
            p2_reg   <= 16'(8'd255 - base_value) * 16'(8'd255 - blend_value);
            bb_reg   <= 16'(base_value) * 16'(8'd255 - base_value);
            sq_reg   <= sqrt_tab[base_value];
            b_reg    <= base_value;
            l_reg    <= blend_value;
            beat_reg <= beat_next;
        end
    end

    assign bs  = 28'(b_reg);
    assign ls  = 28'(l_reg);
    assign p1s = 28'(p1_reg);
    assign p2s = 28'(p2_reg);
    assign bbs = 28'(bb_reg);
    assign sqs = 28'(sq_reg);

    always_comb
    begin
        n = ls;
        d = 16'd1;
        case (mode)
            MODE_MULTIPLY:
            begin
                n = p1s;
                d = 16'd255;
            end
            MODE_SCREEN:
            begin
                n = 28'sd65025 - p2s;
                d = 16'd255;
            end
            MODE_OVERLAY:
            begin
                n = b_reg[7] ? 28'sd65025 - 28'sd2 * p2s : 28'sd2 * p1s;
                d = 16'd255;
            end
            MODE_HARD:
            begin
                n = l_reg[7] ? 28'sd65025 - 28'sd2 * p2s : 28'sd2 * p1s;
                d = 16'd255;
            end
            MODE_SOFT:
            begin
                if (!l_reg[7])
                begin
                    n = 28'sd65025 * bs - (28'sd255 - 28'sd2 * ls) * bbs;
                    d = 16'd65025;
                end
                else
                begin
                    n = 28'sd65280 * bs
                        + (28'sd2 * ls - 28'sd255) * (28'sd255 * sqs - 28'sd256 * bs);
                    d = 16'd65280;
                end
            end
            MODE_DODGE:
            begin
                if (l_reg == 8'd255)
                begin
                    n = 28'sd255;
                    d = 16'd1;
                end
                else
                begin
                    n = 28'sd255 * bs;
                    d = 16'(8'd255 - l_reg);
                end
            end
            MODE_BURN:
            begin
                if (l_reg == 8'd0)
                begin
                    n = 28'sd0;
                    d = 16'd1;
                end
                else
                begin
                    n = 28'sd255 * (ls + bs - 28'sd255);
                    d = 16'(l_reg);
                end
            end
            MODE_DARKEN:  n = (b_reg < l_reg) ? bs : ls;
            MODE_LIGHTEN: n = (b_reg > l_reg) ? bs : ls;
            MODE_DIFF:    n = (b_reg > l_reg) ? bs - ls : ls - bs;
            MODE_EXCL:
            begin
                n = 28'sd255 * (bs + ls) - 28'sd2 * p1s;
                d = 16'd255;
            end
            default:
            begin
                n = ls;
                d = 16'd1;
            end
        endcase
    end

    always_comb
    begin
        beat_next      = '0;
        beat_next.rem  = n[27] ? '0 : n[REM_W-1:0];
        beat_next.div  = d;
        beat_next.quo  = 8'd0;
        beat_next.sat  = 1'b0;
        beat_next.base = b_reg;
    end

    assign out_valid = b_valid_reg;
    assign out_beat  = beat_reg;

endmodule
`default_nettype wire

// ===== design/lbm_div_cell.sv =====
`default_nettype none
module lbm_div_cell #(
    parameter int K = 7
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  wire                    in_valid,
    input  lbm_pkg::div_beat_t     in_beat,
    output logic                   out_valid,
    output lbm_pkg::div_beat_t     out_beat
);
    import lbm_pkg::*;

    logic             valid_reg;
    div_beat_t        beat_reg, beat_next;
    logic [REM_W-1:0] step, over;
    logic             ge;

    assign step = REM_W'(in_beat.div) << K;
    assign over = REM_W'(in_beat.div) << (K + 1);
    assign ge   = in_beat.rem >= step;

    always_comb
    begin
        beat_next     = in_beat;
        beat_next.rem = ge ? in_beat.rem - step : in_beat.rem;
        beat_next.quo = in_beat.quo | (8'(ge) << K);
        beat_next.sat = in_beat.sat | (in_beat.rem >= over);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule
`default_nettype wire

// ===== design/lbm_mix.sv =====
`default_nettype none
module lbm_mix #(
    parameter int OPACITY_FRAC_BITS = 8
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  wire                    in_valid,
    input  lbm_pkg::div_beat_t     in_beat,
    input  wire  [8:0]             opacity,
    output logic                   out_valid,
    output logic [7:0]             mixed_value
);
    import lbm_pkg::*;

    localparam int OPW  = (OPACITY_FRAC_BITS + 1 > 9) ? OPACITY_FRAC_BITS + 1 : 9;
    localparam int SUMW = OPW + 9;
    localparam logic [OPW-1:0]  ONE  = OPW'(1) << OPACITY_FRAC_BITS;
    localparam logic [SUMW-1:0] HALF = SUMW'(ONE >> 1);

    logic            valid_reg;
    logic [7:0]      mixed_reg, mixed_next;
    logic [OPW-1:0]  op, opx;
    logic [7:0]      m;
    logic [SUMW-1:0] sum, v;

    assign opx = OPW'(opacity);
    assign op  = (opx > ONE) ? ONE : opx;
    assign m   = in_beat.sat ? 8'd255 : in_beat.quo;
    assign sum = SUMW'(in_beat.base) * SUMW'(ONE - op) + SUMW'(m) * SUMW'(op) + HALF;
    assign v   = sum >> OPACITY_FRAC_BITS;
    assign mixed_next = (v > SUMW'(255)) ? 8'd255 : v[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mixed_reg <= mixed_next;
        end
    end

    assign out_valid   = valid_reg;
    assign mixed_value = mixed_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import lbm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  base_value = '0;
    logic [7:0]  blend_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  mixed_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    layer_blend_mode_mixer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .base_value(base_value), .blend_value(blend_value),
        .out_valid(out_valid), .out_ready(out_ready), .mixed_value(mixed_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    typedef struct {
        logic [7:0] b;
        logic [7:0] l;
    } pixel_t;

    pixel_t     pixel_q[$];
    logic [7:0] mixed_q[$];
    int         errors = 0;
    int         cycles = 0;
    int         accepted = 0;
    int         calm_in = 0;
    int         calm_out = 0;
    logic       in_taken = 1'b0;
    logic [3:0] cur_mode = MODE_NORMAL;
    logic [8:0] cur_opacity = 9'd256;

    function automatic int root_q8(int b);
        int s;
        s = 0;
        while (s < 256 && 255 * (s + 1) * (s + 1) <= 65536 * b)
            s++;
        if (255 * (2 * s + 1) * (2 * s + 1) <= 4 * 65536 * b)
            s++;
        return s;
    endfunction

    function automatic int sat8(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic int layer_mode(logic [3:0] mode, int b, int l);
        int n;
        case (mode)
            MODE_MULTIPLY: return sat8((b * l) / 255);
            MODE_SCREEN:   return sat8((65025 - (255 - b) * (255 - l)) / 255);
            MODE_OVERLAY:
                if (b < 128) return sat8((2 * b * l) / 255);
                else return sat8((65025 - 2 * (255 - b) * (255 - l)) / 255);
            MODE_SOFT:
            begin
                if (l < 128)
                    return sat8((65025 * b - (255 - 2 * l) * b * (255 - b)) / 65025);
                n = 65280 * b + (2 * l - 255) * (255 * root_q8(b) - 256 * b);
                if (n <= 0) return 0;
                return sat8(n / 65280);
            end
            MODE_HARD:
                if (l < 128) return sat8((2 * b * l) / 255);
                else return sat8((65025 - 2 * (255 - b) * (255 - l)) / 255);
            MODE_DODGE:
                if (l >= 255) return 255;
                else return sat8((b * 255) / (255 - l));
            MODE_BURN:
            begin
                if (l <= 0) return 0;
                n = 255 * l - 255 * (255 - b);
                if (n <= 0) return 0;
                return sat8(n / l);
            end
            MODE_DARKEN:   return b < l ? b : l;
            MODE_LIGHTEN:  return b > l ? b : l;
            MODE_DIFF:     return b > l ? b - l : l - b;
            MODE_EXCL:     return sat8((255 * (b + l) - 2 * b * l) / 255);
            default:       return l;
        endcase
    endfunction

    function automatic logic [7:0] mixed_pixel(int b, int l);
        int op;
        int m;
        int v;
        op = cur_opacity > 256 ? 256 : int'(cur_opacity);
        m = layer_mode(cur_mode, b, l);
        v = (b * (256 - op) + m * op + 128) >>> 8;
        return 8'(v > 255 ? 255 : v);
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pixel_q.size() > 0 && (calm_in > 0 || $urandom_range(99) >= 22))
                begin
                    in_valid    <= 1'b1;
                    base_value  <= pixel_q[0].b;
                    blend_value <= pixel_q[0].l;
                    mixed_q.push_back(mixed_pixel(pixel_q[0].b, pixel_q[0].l));
                    void'(pixel_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= (calm_out > 0) || ($urandom_range(99) >= 22);
            if (calm_in > 0) calm_in <= calm_in - 1;
            if (calm_out > 0) calm_out <= calm_out - 1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
            accepted <= accepted + 1;
        if (out_valid && out_ready)
        begin
            if (mixed_q.size() == 0)
            begin
                $error("unexpected beat mixed_value %0d", mixed_value);
                errors++;
            end
            else
            begin
                if (mixed_value !== mixed_q[0])
                begin
                    $error("mixed_value expected %0d actual %0d", mixed_q[0], mixed_value);
                    errors++;
                end
                void'(mixed_q.pop_front());
            end
        end
        if (cycles > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr[2] == 1'b0) cur_mode = data[3:0];
        else cur_opacity = data[8:0];
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || mixed_q.size() > 0 || in_valid) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_pixel(int b, int l);
        pixel_t p;
        p.b = 8'(b);
        p.l = 8'(l);
        pixel_q.push_back(p);
    endtask

    initial
    begin
        int ops[6];
        ops = '{0, 1, 128, 255, 256, 511};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed corners, reset settings then each mode
        add_pixel(0, 0); add_pixel(255, 255); add_pixel(0, 255); add_pixel(255, 0);
        drain();
        for (int m = 0; m < 16; m++)
        begin
            reg_write(3'd0, 32'(m));
            add_pixel(0, 0); add_pixel(255, 0); add_pixel(0, 255);
            add_pixel(127, 128); add_pixel(128, 127); add_pixel(200, 255);
            drain();
        end
        reg_write(3'd4, 32'd0);
        reg_write(3'd0, 32'(MODE_DIFF));
        add_pixel(10, 200); add_pixel(255, 0);
        drain();
        reg_write(3'd4, 32'h1FF);
        add_pixel(10, 200); add_pixel(255, 0);
        drain();
        reg_write(3'd2, 32'hFFFF_FFFF);
        reg_write(3'd6, 32'd7);
        for (int ph = 0; ph < 24; ph++)
        begin
            reg_write(3'd0, $urandom);
            reg_write(3'd4, ph < 6 ? 32'(ops[ph]) : $urandom);
            if (ph == 12)
            begin
                calm_in = 300;
                calm_out = 300;
            end
            for (int i = 0; i < 80; i++)
                add_pixel($urandom_range(255), $urandom_range(255));
            drain();
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
design/lbm_pkg.sv
design/lbm_front.sv
design/lbm_div_cell.sv
design/lbm_mix.sv
design/layer_blend_mode_mixer.sv
tb/sv/tb.sv
